// File: design/vsk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_pkg
// Types, codes and saturation helpers for the vertex skinning unit.
// ----------------------------------------------------------------------------
package vsk_pkg;

	localparam int MAX_BONES_DEF = 128;
	localparam int MAT_SLOTS     = 12;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_VEC   = 2'd1;
	localparam logic [1:0] OP_APPLY = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] KIND_POS  = 2'd0;
	localparam logic [1:0] KIND_NRM  = 2'd1;
	localparam logic [1:0] KIND_TAN  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// check selectors
	localparam logic [1:0] CHK_NRM = 2'd0;
	localparam logic [1:0] CHK_TAN = 2'd1;
	localparam logic [1:0] CHK_DOT = 2'd2;

	// Q32.32 limits: 0.81, 1.21 and 0.95
	localparam logic signed [65:0] LEN2_LOW  = 66'sd3478923510;
	localparam logic signed [65:0] LEN2_HIGH = 66'sd5196910428;
	localparam logic signed [65:0] DOT_LIMIT = 66'sd4080218931;

	typedef struct packed {
		logic [1:0]         operation;
		logic [6:0]         bone_number;
		logic [3:0]         matrix_slot;
		logic signed [31:0] element_value;
		logic [1:0]         vector_kind;
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
		logic               handedness_in;
		logic [16:0]        blend_weight;
		logic               last_influence;
	} vsk_req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] nrm_x;
		logic signed [31:0] nrm_y;
		logic signed [31:0] nrm_z;
		logic signed [31:0] tan_x;
		logic signed [31:0] tan_y;
		logic signed [31:0] tan_z;
		logic               handedness_out;
		logic               bad_vertex;
	} vsk_rsp_t;

	typedef struct packed {
		logic       accept;
		logic       mem_rd;
		logic       row_cap;
		logic       acc_init;
		logic       mul;
		logic       chk;
		logic       acc_add;
		logic       wmul;
		logic       wadd;
		logic       chk_init;
		logic       chk_add;
		logic       chk_eval;
		logic       out_load;
		logic [1:0] r;
		logic [1:0] k;
		logic [1:0] c;
		logic [1:0] j;
	} vsk_cmd_t;

	typedef struct packed {
		logic is_apply;
		logic bone_ok;
		logic last_now;
		logic last_q;
	} vsk_sts_t;

	function automatic logic signed [31:0] sat32_50(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -50'sd2147483648)
			return 32'sh80000000;
		else
			return signed'(v[31:0]);
	endfunction

	function automatic logic signed [31:0] sat32_48(input logic signed [47:0] v);
		if (v > 48'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -48'sd2147483648)
			return 32'sh80000000;
		else
			return signed'(v[31:0]);
	endfunction

	function automatic logic signed [47:0] sat48_49(input logic signed [48:0] v);
		if (v > 49'sh0_7FFF_FFFF_FFFF)
			return 48'sh7FFF_FFFF_FFFF;
		else if (v < -49'sh0_8000_0000_0000)
			return 48'sh8000_0000_0000;
		else
			return signed'(v[47:0]);
	endfunction

endpackage

// File: design/vsk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_ctrl
// Sequencer: walks matrix rows, vertex vectors and the check terms.
// ----------------------------------------------------------------------------
module vsk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	input  vsk_pkg::vsk_sts_t sts,
	output vsk_pkg::vsk_cmd_t cmd
);
	import vsk_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDA   = 4'd1;
	localparam logic [3:0] ST_RDW   = 4'd2;
	localparam logic [3:0] ST_ACCI  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_ADD   = 4'd5;
	localparam logic [3:0] ST_WMUL  = 4'd6;
	localparam logic [3:0] ST_WADD  = 4'd7;
	localparam logic [3:0] ST_CINIT = 4'd8;
	localparam logic [3:0] ST_CMUL  = 4'd9;
	localparam logic [3:0] ST_CADD  = 4'd10;
	localparam logic [3:0] ST_CEVAL = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	logic [3:0] state_q;
	logic [1:0] r_q, k_q, c_q, j_q;
	logic       out_free;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.r        = r_q;
		cmd.k        = k_q;
		cmd.c        = c_q;
		cmd.j        = j_q;
		cmd.accept   = req_valid && (state_q == ST_IDLE);
		cmd.mem_rd   = (state_q == ST_RDA);
		cmd.row_cap  = (state_q == ST_RDW);
		cmd.acc_init = (state_q == ST_ACCI);
		cmd.mul      = (state_q == ST_MUL) || (state_q == ST_CMUL);
		cmd.chk      = (state_q == ST_CMUL);
		cmd.acc_add  = (state_q == ST_ADD);
		cmd.wmul     = (state_q == ST_WMUL);
		cmd.wadd     = (state_q == ST_WADD);
		cmd.chk_init = (state_q == ST_CINIT);
		cmd.chk_add  = (state_q == ST_CADD);
		cmd.chk_eval = (state_q == ST_CEVAL);
		cmd.out_load = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			r_q       <= '0;
			k_q       <= '0;
			c_q       <= '0;
			j_q       <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.out_load)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					r_q <= '0;
					k_q <= '0;
					c_q <= '0;
					j_q <= '0;
					if (cmd.accept && sts.is_apply) begin
						if (sts.bone_ok)
							state_q <= ST_RDA;
						else if (sts.last_now)
							state_q <= ST_CINIT;
					end
				end
				ST_RDA: state_q <= ST_RDW;
				ST_RDW: begin
					if (c_q == 2'd3) begin
						k_q     <= '0;
						state_q <= ST_ACCI;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= ST_RDA;
					end
				end
				ST_ACCI: begin
					c_q     <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (c_q == 2'd2) begin
						state_q <= ST_WMUL;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_WMUL: state_q <= ST_WADD;
				ST_WADD: begin
					if (k_q != 2'd2) begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_ACCI;
					end else if (r_q != 2'd2) begin
						r_q     <= r_q + 2'd1;
						c_q     <= '0;
						state_q <= ST_RDA;
					end else if (sts.last_q) begin
						j_q     <= '0;
						state_q <= ST_CINIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CINIT: begin
					c_q     <= '0;
					state_q <= ST_CMUL;
				end
				ST_CMUL: state_q <= ST_CADD;
				ST_CADD: begin
					if (c_q == 2'd2) begin
						state_q <= ST_CEVAL;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= ST_CMUL;
					end
				end
				ST_CEVAL: begin
					if (j_q == CHK_DOT) begin
						state_q <= ST_OUT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= ST_CINIT;
					end
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/vsk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_dp
// Datapath: matrix store, vertex registers, shared multiplier, blend sums.
// ----------------------------------------------------------------------------
module vsk_dp #(
	parameter int MAX_BONES = vsk_pkg::MAX_BONES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vsk_pkg::vsk_req_t req,
	input  vsk_pkg::vsk_cmd_t cmd,
	output vsk_pkg::vsk_sts_t sts,
	output vsk_pkg::vsk_rsp_t rsp
);
	import vsk_pkg::*;

	localparam int DEPTH = MAX_BONES * MAT_SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = AW + 8;

	logic [31:0]        mat_mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic signed [31:0] row_q [4];
	logic signed [31:0] vec_q [9];
	logic [6:0]         bone_q;
	logic [16:0]        w_q;
	logic               last_q;
	logic               tsign_q;
	logic               bad_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] acc_q;
	logic signed [49:0] wprod_q;
	logic signed [65:0] chk_q;
	logic signed [47:0] sums_q [9];

	logic               bone_ok, slot_ok;
	logic [TW-1:0]      waddr, raddr;
	logic signed [31:0] op_a, op_b, acc_sat;
	logic [3:0]         vidx, sidx;
	logic [3:0]         vbase;

	assign bone_ok = (32'(req.bone_number) < MAX_BONES);
	assign slot_ok = (32'(req.matrix_slot) < MAT_SLOTS);
	assign waddr   = TW'(req.bone_number) * TW'(MAT_SLOTS) + TW'(req.matrix_slot);
	assign raddr   = TW'(bone_q) * TW'(MAT_SLOTS) + TW'({cmd.r, 2'b00}) + TW'(cmd.c);

	assign sts.is_apply = (req.operation == OP_APPLY);
	assign sts.bone_ok  = bone_ok;
	assign sts.last_now = req.last_influence;
	assign sts.last_q   = last_q;

	assign vidx    = 4'(cmd.k) * 4'd3 + 4'(cmd.c);
	assign sidx    = 4'(cmd.k) * 4'd3 + 4'(cmd.r);
	assign acc_sat = sat32_50(acc_q);

	// operand select: skinning uses matrix row x vertex vector,
	// the check uses normal/tangent pairs
	always_comb begin
		op_a = row_q[cmd.c];
		op_b = vec_q[vidx];
		if (cmd.chk) begin
			op_a = (cmd.j == CHK_TAN) ? vec_q[4'd6 + 4'(cmd.c)] : vec_q[4'd3 + 4'(cmd.c)];
			op_b = (cmd.j == CHK_NRM) ? vec_q[4'd3 + 4'(cmd.c)] : vec_q[4'd6 + 4'(cmd.c)];
		end
	end

	always_comb begin
		case (req.vector_kind)
			KIND_POS: vbase = 4'd0;
			KIND_NRM: vbase = 4'd3;
			KIND_TAN: vbase = 4'd6;
			default:  vbase = 4'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && req.operation == OP_LOAD && bone_ok && slot_ok)
			mat_mem[waddr[AW-1:0]] <= req.element_value;
		if (cmd.mem_rd)
			rdata_q <= mat_mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && req.operation == OP_VEC && req.vector_kind != KIND_NONE) begin
			vec_q[vbase]        <= req.comp_x;
			vec_q[vbase + 4'd1] <= req.comp_y;
			vec_q[vbase + 4'd2] <= req.comp_z;
		end
		if (cmd.accept) begin
			bone_q <= req.bone_number;
			w_q    <= req.blend_weight;
			last_q <= req.last_influence;
		end
		if (cmd.row_cap)
			row_q[cmd.c] <= rdata_q;
		if (cmd.mul)
			prod_q <= op_a * op_b;
		if (cmd.acc_init)
			acc_q <= (cmd.k == 2'd0) ? 50'(row_q[3]) : '0;
		else if (cmd.acc_add)
			acc_q <= acc_q + 50'(prod_q >>> 16);
		if (cmd.wmul)
			wprod_q <= acc_sat * $signed({1'b0, w_q});
		if (cmd.chk_init)
			chk_q <= '0;
		else if (cmd.chk_add)
			chk_q <= chk_q + 66'(prod_q);
		if (cmd.chk_init && cmd.j == CHK_NRM)
			bad_q <= 1'b0;
		else if (cmd.chk_eval) begin
			if (cmd.j == CHK_DOT)
				bad_q <= bad_q | (chk_q > DOT_LIMIT) | (chk_q < -DOT_LIMIT);
			else
				bad_q <= bad_q | (chk_q < LEN2_LOW) | (chk_q > LEN2_HIGH);
		end
		if (cmd.out_load) begin
			rsp.pos_x          <= sat32_48(sums_q[0]);
			rsp.pos_y          <= sat32_48(sums_q[1]);
			rsp.pos_z          <= sat32_48(sums_q[2]);
			rsp.nrm_x          <= sat32_48(sums_q[3]);
			rsp.nrm_y          <= sat32_48(sums_q[4]);
			rsp.nrm_z          <= sat32_48(sums_q[5]);
			rsp.tan_x          <= sat32_48(sums_q[6]);
			rsp.tan_y          <= sat32_48(sums_q[7]);
			rsp.tan_z          <= sat32_48(sums_q[8]);
			rsp.handedness_out <= tsign_q;
			rsp.bad_vertex     <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsign_q <= 1'b0;
			for (int i = 0; i < 9; i++)
				sums_q[i] <= '0;
		end else begin
			if (cmd.accept && req.operation == OP_VEC && req.vector_kind == KIND_TAN)
				tsign_q <= req.handedness_in;
			if (cmd.out_load) begin
				for (int i = 0; i < 9; i++)
					sums_q[i] <= '0;
			end else if (cmd.wadd) begin
				sums_q[sidx] <= sat48_49(49'(sums_q[sidx]) + 49'(wprod_q >>> 16));
			end
		end
	end

endmodule

// File: design/vertex_skinning_with_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_skinning_with_check_unit
// Linear blend skinning in Q16.16 with a normal/tangent sanity check.
// ----------------------------------------------------------------------------
// Matrix loads and vertex vector writes are taken without leaving the idle
// state. An influence request keeps the unit busy: per matrix row, four reads
// of the single-port matrix store and three dot/weight passes whose dot
// products run on the one shared 32x32 multiplier, which sets the pace. A last
// influence adds the check (nine products on the same multiplier) and then
// loads the output register; an influence on a bone number of MAX_BONES or
// above skips the matrix work. The result sits in an output register, so a
// new request is taken while it waits; on the output side the unit only holds
// off when a second result is ready before the first was taken. Matrix store
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module vertex_skinning_with_check_unit #(
	parameter int MAX_BONES = vsk_pkg::MAX_BONES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  vsk_pkg::vsk_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output vsk_pkg::vsk_rsp_t rsp
);
	import vsk_pkg::*;

	vsk_cmd_t cmd;
	vsk_sts_t sts;

	// sequencer
	vsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and storage
	vsk_dp #(.MAX_BONES(MAX_BONES)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

	// output register is only overwritten once the previous result is gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid || !rsp_stall))
		else $error("result overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid)
		else $error("loaded result not presented");

	// an influence on a bone in range always goes busy
	a_apply_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.is_apply && sts.bone_ok) |=> req_stall)
		else $error("influence request not sequenced");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex skinning unit: matrix loads, vertex
// vector writes and bone influences are sent through the request channel.
// A bit-true predictor queues the expected vertex results, and a monitor
// compares each result with the oldest one, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import vsk_pkg::*;

	localparam int NBONES = MAX_BONES_DEF;
	localparam logic [63:0] LEN_LO  = 64'd3478923510;
	localparam logic [63:0] LEN_HI  = 64'd5196910428;
	localparam logic [63:0] DOT_LIM = 64'd4080218931;
	localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint S48_MIN = -64'sh8000_0000_0000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	vsk_req_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	vsk_rsp_t  rsp;

	// idling percentages, changed per phase
	int        send_idle = 0;
	int        recv_stall = 0;
	// long hold-off on the result side, in cycles
	int        hold_cycles = 0;

	int        err_cnt = 0;
	int        req_cnt = 0;
	int        vtx_cnt = 0;

	// predictor state
	logic signed [31:0] mat_store [NBONES*12];
	bit                 mat_written [NBONES*12];
	logic signed [31:0] vtx_vec [9];
	logic               tan_sign = 1'b0;
	longint             skin_sum [9];

	vsk_rsp_t  vertex_q [$];

	always #10 clk = ~clk;

	vertex_skinning_with_check_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint floor16(longint v);
		return v >>> 16;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip48(longint v);
		if (v > S48_MAX) return S48_MAX;
		if (v < S48_MIN) return S48_MIN;
		return v;
	endfunction

	function automatic logic [63:0] mag(logic signed [31:0] v);
		longint t;
		t = v;
		return (t < 0) ? -t : t;
	endfunction

	function automatic bit len_out(int base);
		logic [63:0] s;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += mag(vtx_vec[base+i]) * mag(vtx_vec[base+i]);
		return (s < LEN_LO) || (s > LEN_HI);
	endfunction

	function automatic bit dot_out();
		logic [63:0] p, n, t;
		p = 0;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			t = mag(vtx_vec[3+i]) * mag(vtx_vec[6+i]);
			if (vtx_vec[3+i][31] != vtx_vec[6+i][31])
				n += t;
			else
				p += t;
		end
		return (p > n) ? (p - n > DOT_LIM) : (n - p > DOT_LIM);
	endfunction

	task automatic predict_skin(input vsk_req_t r);
		longint acc [3];
		longint v;
		vsk_rsp_t e;
		int b;
		b = r.bone_number;
		case (r.operation)
			OP_LOAD: begin
				if (b < NBONES && r.matrix_slot < MAT_SLOTS) begin
					mat_store[b*12 + r.matrix_slot] = r.element_value;
					mat_written[b*12 + r.matrix_slot] = 1'b1;
				end
			end
			OP_VEC: begin
				if (r.vector_kind != KIND_NONE) begin
					vtx_vec[r.vector_kind*3 + 0] = r.comp_x;
					vtx_vec[r.vector_kind*3 + 1] = r.comp_y;
					vtx_vec[r.vector_kind*3 + 2] = r.comp_z;
					if (r.vector_kind == KIND_TAN)
						tan_sign = r.handedness_in;
				end
			end
			OP_APPLY: begin
				if (b < NBONES) begin
					for (int row = 0; row < 3; row++) begin
						for (int k = 0; k < 3; k++) begin
							acc[k] = 0;
							for (int c = 0; c < 3; c++)
								acc[k] += floor16(longint'(mat_store[b*12 + row*4 + c]) *
									longint'(vtx_vec[k*3 + c]));
						end
						acc[0] += mat_store[b*12 + row*4 + 3];
						for (int k = 0; k < 3; k++) begin
							v = clip32(acc[k]);
							skin_sum[k*3+row] = clip48(skin_sum[k*3+row] +
								floor16(v * longint'({15'd0, r.blend_weight})));
						end
					end
				end
				if (r.last_influence) begin
					e.pos_x = 32'(clip32(skin_sum[0]));
					e.pos_y = 32'(clip32(skin_sum[1]));
					e.pos_z = 32'(clip32(skin_sum[2]));
					e.nrm_x = 32'(clip32(skin_sum[3]));
					e.nrm_y = 32'(clip32(skin_sum[4]));
					e.nrm_z = 32'(clip32(skin_sum[5]));
					e.tan_x = 32'(clip32(skin_sum[6]));
					e.tan_y = 32'(clip32(skin_sum[7]));
					e.tan_z = 32'(clip32(skin_sum[8]));
					e.handedness_out = tan_sign;
					e.bad_vertex = len_out(3) || len_out(6) || dot_out();
					vertex_q.push_back(e);
					for (int i = 0; i < 9; i++)
						skin_sum[i] = 0;
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: one request, with random idle cycles before it
	// ------------------------------------------------------------------
	task automatic send_req(input vsk_req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_skin(r);
		req_cnt++;
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	// random filler for fields the operation does not use
	function automatic vsk_req_t noise_req();
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(vsk_req_t)-1:0];
	endfunction

	task automatic load_elem(input int b, input int s, input logic [31:0] v);
		vsk_req_t r;
		r = noise_req();
		r.operation = OP_LOAD;
		r.bone_number = 7'(b);
		r.matrix_slot = 4'(s);
		r.element_value = v;
		send_req(r);
	endtask

	task automatic set_vec(input logic [1:0] k, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic h);
		vsk_req_t r;
		r = noise_req();
		r.operation = OP_VEC;
		r.vector_kind = k;
		r.comp_x = x;
		r.comp_y = y;
		r.comp_z = z;
		r.handedness_in = h;
		send_req(r);
	endtask

	task automatic apply_bone(input int b, input logic [16:0] w, input logic last);
		vsk_req_t r;
		r = noise_req();
		r.operation = OP_APPLY;
		r.bone_number = 7'(b);
		r.blend_weight = w;
		r.last_influence = last;
		send_req(r);
	endtask

	// random value: mostly near unit scale, sometimes extreme
	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $signed($urandom_range(262143)) - 32'sd131072;
		endcase
	endfunction

	function automatic logic [31:0] rnd_unit();
		return $signed($urandom_range(131072)) - 32'sd65536;
	endfunction

	task automatic load_bone(input int b);
		for (int s = 0; s < MAT_SLOTS; s++)
			load_elem(b, s, rnd_val());
	endtask

	task automatic set_vertex();
		set_vec(KIND_POS, rnd_val(), rnd_val(), rnd_val(), 1'($urandom));
		if ($urandom_range(1)) begin
			set_vec(KIND_NRM, rnd_unit(), rnd_unit(), rnd_unit(), 1'($urandom));
			set_vec(KIND_TAN, rnd_unit(), rnd_unit(), rnd_unit(), 1'($urandom));
		end else begin
			// near-unit axis vectors, mostly passing the check
			set_vec(KIND_NRM, 32'sd65536 + $signed($urandom_range(2000)) - 1000, 0,
				$signed($urandom_range(20000)) - 10000, 1'($urandom));
			set_vec(KIND_TAN, $signed($urandom_range(20000)) - 10000,
				32'sd65536 - $urandom_range(3000), 0, 1'($urandom));
		end
	endtask

	function automatic logic [16:0] rnd_weight();
		case ($urandom_range(5))
			0: return 17'd65536;
			1: return 17'($urandom);
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	// every element of the bone has been loaded
	function automatic bit bone_full(input int b);
		for (int s = 0; s < MAT_SLOTS; s++)
			if (!mat_written[b*12 + s]) return 1'b0;
		return 1'b1;
	endfunction

	// a bone already fully loaded
	function automatic int loaded_bone();
		int b;
		for (int t = 0; t < 64; t++) begin
			b = $urandom_range(NBONES - 1);
			if (bone_full(b)) return b;
		end
		return 0;
	endfunction

	task automatic wait_drain();
		while (vertex_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Monitor and receiver stall
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			rsp_stall <= ($urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		vsk_rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (vertex_q.size() == 0) begin
				$error("unexpected vertex result");
				err_cnt++;
			end else begin
				e = vertex_q.pop_front();
				vtx_cnt++;
				if (rsp.pos_x !== e.pos_x) begin
					$error("pos_x exp %0d got %0d", e.pos_x, rsp.pos_x); err_cnt++; end
				if (rsp.pos_y !== e.pos_y) begin
					$error("pos_y exp %0d got %0d", e.pos_y, rsp.pos_y); err_cnt++; end
				if (rsp.pos_z !== e.pos_z) begin
					$error("pos_z exp %0d got %0d", e.pos_z, rsp.pos_z); err_cnt++; end
				if (rsp.nrm_x !== e.nrm_x) begin
					$error("nrm_x exp %0d got %0d", e.nrm_x, rsp.nrm_x); err_cnt++; end
				if (rsp.nrm_y !== e.nrm_y) begin
					$error("nrm_y exp %0d got %0d", e.nrm_y, rsp.nrm_y); err_cnt++; end
				if (rsp.nrm_z !== e.nrm_z) begin
					$error("nrm_z exp %0d got %0d", e.nrm_z, rsp.nrm_z); err_cnt++; end
				if (rsp.tan_x !== e.tan_x) begin
					$error("tan_x exp %0d got %0d", e.tan_x, rsp.tan_x); err_cnt++; end
				if (rsp.tan_y !== e.tan_y) begin
					$error("tan_y exp %0d got %0d", e.tan_y, rsp.tan_y); err_cnt++; end
				if (rsp.tan_z !== e.tan_z) begin
					$error("tan_z exp %0d got %0d", e.tan_z, rsp.tan_z); err_cnt++; end
				if (rsp.handedness_out !== e.handedness_out) begin
					$error("handedness_out exp %0b got %0b", e.handedness_out,
						rsp.handedness_out);
					err_cnt++;
				end
				if (rsp.bad_vertex !== e.bad_vertex) begin
					$error("bad_vertex exp %0b got %0b", e.bad_vertex, rsp.bad_vertex);
					err_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// extremes, ignored items, highest bone, heavy weight
	task automatic test_directed();
		int b;
		b = NBONES - 1;
		load_elem(0, 0, 32'h7FFFFFFF);
		load_elem(0, 1, 32'h80000000);
		for (int s = 2; s < MAT_SLOTS; s++) load_elem(0, s, 32'h00010000);
		for (int s = 0; s < MAT_SLOTS; s++) load_elem(b, s, 32'h80000000);
		load_elem(0, 13, 32'h12345678);          // slot past the matrix: ignored
		set_vec(KIND_NONE, 32'h1, 32'h2, 32'h3, 1'b1); // unused kind: ignored
		set_vec(KIND_POS, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1);
		set_vec(KIND_NRM, 32'h00010000, 32'h0, 32'h0, 1'b1);
		set_vec(KIND_TAN, 32'h0, 32'h00010000, 32'h0, 1'b1);
		apply_bone(0, 17'd65536, 1'b0);
		apply_bone(b, 17'h1FFFF, 1'b1);          // saturating sums
		apply_bone(0, 17'd0, 1'b1);
		set_vec(KIND_TAN, 32'h00010000, 32'h0, 32'h0, 1'b0); // dot check fails
		apply_bone(0, 17'd32768, 1'b1);
		begin
			vsk_req_t r;
			r = noise_req();
			r.operation = OP_NOP;                // ignored operation
			send_req(r);
		end
		wait_drain();
	endtask

	task automatic random_phase(input int n_items, input int si, input int rs);
		int start;
		int nb;
		send_idle = si;
		recv_stall = rs;
		start = req_cnt;
		while (req_cnt - start < n_items) begin
			case ($urandom_range(9))
				0: load_bone($urandom_range(NBONES - 1));
				1: load_elem($urandom, $urandom, $urandom); // partial or ignored
				default: begin
					set_vertex();
					nb = $urandom_range(4, 1);
					for (int i = 0; i < nb; i++)
						apply_bone(($urandom_range(15) == 0) ? NBONES - 1 : loaded_bone(),
							rnd_weight(), i == nb - 1);
				end
			endcase
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 3000;
		send_idle = 0;
		recv_stall = 0;
		for (int v = 0; v < 6; v++) begin
			set_vertex();
			apply_bone(loaded_bone(), rnd_weight(), 1'b1);
		end
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < 9; i++) skin_sum[i] = 0;
		foreach (mat_written[i]) mat_written[i] = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		load_bone(1);
		load_bone(2);
		random_phase(215, 0, 0);
		random_phase(215, 47, 0);
		random_phase(215, 0, 47);
		random_phase(215, 35, 35);
		test_backpressure();
		$display("Run sent %0d requests and checked %0d skinned vertices", req_cnt, vtx_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: vertex_skinning_with_check_unit.f
design/vsk_pkg.sv
design/vsk_ctrl.sv
design/vsk_dp.sv
design/vertex_skinning_with_check_unit.sv
verif/tb_top.sv
